// ----- design/dstwr_pkg.sv -----
// Shared types and codes for the DS-TWR initiator sequencer.
// Holds the event and command structs, phase encoding and field codes.
// No dependencies.
package dstwr_pkg;

  // Event codes carried in the op field.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_TX_DONE = 2'd1;
  localparam logic [1:0] OP_RX_DONE = 2'd2;
  localparam logic [1:0] OP_RSVD    = 2'd3;

  // Transmit commands.
  localparam logic [1:0] TX_NONE  = 2'd0;
  localparam logic [1:0] TX_SYNC  = 2'd1;
  localparam logic [1:0] TX_POLL  = 2'd2;
  localparam logic [1:0] TX_FINAL = 2'd3;

  // Timestamp capture commands.
  localparam logic [1:0] CAP_NONE    = 2'd0;
  localparam logic [1:0] CAP_POLL_TX = 2'd1;
  localparam logic [1:0] CAP_RESP_RX = 2'd2;
  localparam logic [1:0] CAP_FINAL_TX = 2'd3;

  // Round status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SYNC_TX   = 3'd1;
  localparam logic [2:0] ST_SYNC_RX   = 3'd2;
  localparam logic [2:0] ST_POLL_TX   = 3'd3;
  localparam logic [2:0] ST_RESP_RX   = 3'd4;
  localparam logic [2:0] ST_FINAL_TX  = 3'd5;
  localparam logic [2:0] ST_RESULT_RX = 3'd6;
  localparam logic [2:0] ST_OTHER     = 3'd7;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TIME      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_WAIT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERALL_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_PATTERN     = 3'd4;

  // Configuration reset values.
  localparam logic [15:0] CYCLE_TIME_RST      = 16'd500;
  localparam logic [15:0] ACK_TIMEOUT_RST     = 16'd10;
  localparam logic [15:0] POLL_WAIT_RST       = 16'd1;
  localparam logic [15:0] OVERALL_TIMEOUT_RST = 16'd10;
  localparam logic [23:0] ACK_PATTERN_RST     = 24'h41434B;

  // Sequencer phases, one-hot.
  typedef enum logic [8:0] {
    PH_IDLE       = 9'b000000001,
    PH_SYNC_PEND  = 9'b000000010,
    PH_SYNC_TX    = 9'b000000100,
    PH_SYNC_RX    = 9'b000001000,
    PH_POLL_DELAY = 9'b000010000,
    PH_POLL_TX    = 9'b000100000,
    PH_RESP_RX    = 9'b001000000,
    PH_FINAL_TX   = 9'b010000000,
    PH_RESULT_RX  = 9'b100000000
  } phase_t;

  // One input event.
  typedef struct packed {
    logic [1:0]  op;
    logic        rx_ok;
    logic [23:0] rx_payload;
  } evt_t;

  // One command result.
  typedef struct packed {
    logic [1:0] tx_start;
    logic       rx_start;
    logic       deferred;
    logic       tx_end;
    logic       rx_end;
    logic [1:0] capture;
    logic       round_done;
    logic [2:0] status;
  } res_t;

  // Saturating millisecond counter step.
  function automatic logic [15:0] bump(input logic [15:0] c);
    return (c != 16'hFFFF) ? c + 16'd1 : c;
  endfunction

  // Status reported when the overall timeout hits in a given phase.
  function automatic logic [2:0] status_of(input phase_t ph);
    logic [2:0] st;
    unique case (ph)
      PH_SYNC_TX:   st = ST_SYNC_TX;
      PH_SYNC_RX:   st = ST_SYNC_RX;
      PH_POLL_TX:   st = ST_POLL_TX;
      PH_RESP_RX:   st = ST_RESP_RX;
      PH_FINAL_TX:  st = ST_FINAL_TX;
      PH_RESULT_RX: st = ST_RESULT_RX;
      default:      st = ST_OTHER;
    endcase
    return st;
  endfunction

endpackage

// ----- design/ds_twr_initiator_sequencer.sv -----
// DS-TWR initiator sequencer: event decode, ranging phases and command output.
// Depends on dstwr_pkg for types, codes and helper functions.
// Throughput: one event per cycle while evt_stall is low (skid empty);
// the phase decision is one registered step.
// A two-entry output stage (result register plus skid) keeps input flowing
// while a result waits. Synchronous reset restores register defaults and
// puts the sequencer in the sync-pending phase with all counters cleared.
module ds_twr_initiator_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  // Event channel.
  input  logic                           evt_valid,
  output logic                           evt_stall,
  input  dstwr_pkg::evt_t                evt,
  // Command result channel.
  output logic                           res_valid,
  input  logic                           res_stall,
  output dstwr_pkg::res_t                res,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dstwr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]                    cfg_data
);
  import dstwr_pkg::*;

  // Configuration registers.
  logic [15:0] cycle_time_ms;
  logic [15:0] ack_timeout_ms;
  logic [15:0] poll_wait_ms;
  logic [15:0] overall_timeout_ms;
  logic [23:0] ack_pattern;

  // Sequencer state.
  phase_t      phase, phase_next;
  logic [15:0] wait_count, wait_count_next;
  logic [15:0] overall_count, overall_count_next;
  logic        overall_armed, overall_armed_next;

  // Output stage.
  logic        out_full;
  logic        skid_full;
  res_t        skid;
  res_t        cmd;

  logic        accept;
  logic        take;
  logic [15:0] wait_bumped;
  logic [15:0] overall_bumped;
  logic        consumed;

  assign cfg_ready = 1'b1;
  assign evt_stall = skid_full;
  assign accept    = evt_valid && !skid_full;
  assign take      = out_full && !res_stall;
  assign res_valid = out_full;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_time_ms      <= CYCLE_TIME_RST;
      ack_timeout_ms     <= ACK_TIMEOUT_RST;
      poll_wait_ms       <= POLL_WAIT_RST;
      overall_timeout_ms <= OVERALL_TIMEOUT_RST;
      ack_pattern        <= ACK_PATTERN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CYCLE_TIME:      cycle_time_ms      <= cfg_data[15:0];
        CFG_ACK_TIMEOUT:     ack_timeout_ms     <= cfg_data[15:0];
        CFG_POLL_WAIT:       poll_wait_ms       <= cfg_data[15:0];
        CFG_OVERALL_TIMEOUT: overall_timeout_ms <= cfg_data[15:0];
        CFG_ACK_PATTERN:     ack_pattern        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Phase decision for the event at the input.
  always_comb begin
    phase_next         = phase;
    wait_count_next    = wait_count;
    overall_count_next = overall_count;
    overall_armed_next = overall_armed;
    cmd                = '0;
    consumed           = 1'b0;
    wait_bumped        = bump(wait_count);
    overall_bumped     = bump(overall_count);

    // The overall timeout takes a tick before anything else sees it.
    if (evt.op == OP_TICK && overall_armed) begin
      overall_count_next = overall_bumped;
      if (overall_bumped >= overall_timeout_ms) begin
        cmd.tx_end         = 1'b1;
        cmd.rx_end         = 1'b1;
        cmd.round_done     = 1'b1;
        cmd.status         = status_of(phase);
        overall_armed_next = 1'b0;
        overall_count_next = '0;
        wait_count_next    = '0;
        phase_next         = PH_IDLE;
        consumed           = 1'b1;
      end
    end

    if (!consumed && evt.op != OP_RSVD) begin
      unique case (phase)
        PH_SYNC_PEND: begin
          cmd.tx_start = TX_SYNC;
          phase_next   = PH_SYNC_TX;
        end
        PH_IDLE: begin
          if (evt.op == OP_TICK) begin
            wait_count_next = wait_bumped;
            if (wait_bumped >= cycle_time_ms) begin
              cmd.tx_start = TX_SYNC;
              phase_next   = PH_SYNC_TX;
            end
          end
        end
        PH_SYNC_TX: begin
          if (evt.op == OP_TX_DONE) begin
            cmd.tx_end      = 1'b1;
            cmd.rx_start    = 1'b1;
            wait_count_next = '0;
            phase_next      = PH_SYNC_RX;
          end
        end
        PH_SYNC_RX: begin
          if (evt.op == OP_TICK) begin
            wait_count_next = wait_bumped;
            if (wait_bumped >= ack_timeout_ms) begin
              cmd.rx_end   = 1'b1;
              cmd.tx_start = TX_SYNC;
              phase_next   = PH_SYNC_TX;
            end
          end else if (evt.op == OP_RX_DONE) begin
            cmd.rx_end = 1'b1;
            if (evt.rx_ok && evt.rx_payload == ack_pattern) begin
              wait_count_next = '0;
              if (poll_wait_ms == '0) begin
                overall_count_next = '0;
                overall_armed_next = 1'b1;
                cmd.tx_start       = TX_POLL;
                phase_next         = PH_POLL_TX;
              end else begin
                phase_next = PH_POLL_DELAY;
              end
            end else begin
              cmd.tx_start = TX_SYNC;
              phase_next   = PH_SYNC_TX;
            end
          end
        end
        PH_POLL_DELAY: begin
          if (evt.op == OP_TICK) begin
            wait_count_next = wait_bumped;
            if (wait_bumped >= poll_wait_ms) begin
              overall_count_next = '0;
              overall_armed_next = 1'b1;
              cmd.tx_start       = TX_POLL;
              phase_next         = PH_POLL_TX;
            end
          end
        end
        PH_POLL_TX: begin
          if (evt.op == OP_TX_DONE) begin
            cmd.capture  = CAP_POLL_TX;
            cmd.tx_end   = 1'b1;
            cmd.rx_start = 1'b1;
            cmd.deferred = 1'b1;
            phase_next   = PH_RESP_RX;
          end
        end
        PH_RESP_RX: begin
          if (evt.op == OP_RX_DONE) begin
            cmd.capture  = CAP_RESP_RX;
            cmd.rx_end   = 1'b1;
            cmd.tx_start = TX_FINAL;
            cmd.deferred = 1'b1;
            phase_next   = PH_FINAL_TX;
          end
        end
        PH_FINAL_TX: begin
          if (evt.op == OP_TX_DONE) begin
            cmd.capture  = CAP_FINAL_TX;
            cmd.tx_end   = 1'b1;
            cmd.rx_start = 1'b1;
            phase_next   = PH_RESULT_RX;
          end
        end
        PH_RESULT_RX: begin
          if (evt.op == OP_RX_DONE) begin
            cmd.tx_end         = 1'b1;
            cmd.rx_end         = 1'b1;
            cmd.round_done     = 1'b1;
            cmd.status         = ST_OK;
            overall_armed_next = 1'b0;
            overall_count_next = '0;
            wait_count_next    = '0;
            phase_next         = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_SYNC_PEND;
        end
      endcase
    end
  end

  // State update on each accepted event.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC_PEND;
      wait_count    <= '0;
      overall_count <= '0;
      overall_armed <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      wait_count    <= wait_count_next;
      overall_count <= overall_count_next;
      overall_armed <= overall_armed_next;
    end
  end

  // Output stage: result register in front, skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_full || take) begin
      if (skid_full) begin
        out_full  <= 1'b1;
        skid_full <= accept;
      end else begin
        out_full  <= accept;
      end
    end else if (accept) begin
      skid_full <= 1'b1;
    end
  end

  // Result payloads move without reset.
  always_ff @(posedge clk) begin
    if (!out_full || take) begin
      if (skid_full) begin
        res <= skid;
        if (accept) begin
          skid <= cmd;
        end
      end else if (accept) begin
        res <= cmd;
      end
    end else if (accept) begin
      skid <= cmd;
    end
  end

endmodule
